// File: rtl/ovdma_pkg.sv
`default_nettype none

package ovdma_pkg;

	localparam int unsigned SPRITE_TABLE_BYTES = 160;

	localparam logic [7:0]  SPRITE_BYTES      = 8'(SPRITE_TABLE_BYTES);
	localparam logic [6:0]  REMAINING_RESET   = 7'h7F;
	localparam logic [15:0] DEST_RESET        = 16'h8000;
	localparam logic [15:0] DEST_KEEP_MASK    = 16'h80FF;
	localparam logic [7:0]  LOW_BYTE_MASK     = 8'hF0;
	localparam logic [4:0]  DEST_HIGH_MASK    = 5'h1F;
	localparam logic [11:0] BLANK_COPY_BYTES  = 12'h010;
	localparam logic [7:0]  READ_IDLE         = 8'hFF;
	localparam logic [7:0]  STATUS_IDLE_BIT   = 8'h80;

	localparam logic [15:0] ADDR_SPRITE_START = 16'hFF46;
	localparam logic [15:0] ADDR_SRC_HIGH     = 16'hFF51;
	localparam logic [15:0] ADDR_SRC_LOW      = 16'hFF52;
	localparam logic [15:0] ADDR_DEST_HIGH    = 16'hFF53;
	localparam logic [15:0] ADDR_DEST_LOW     = 16'hFF54;
	localparam logic [15:0] ADDR_CONTROL      = 16'hFF55;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_BLANK = 2'd3;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_SPRITE = 2'd1;
	localparam logic [1:0] KIND_BLOCK  = 2'd2;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [1:0]  xfer_kind;
		logic [15:0] xfer_source;
		logic [15:0] xfer_dest;
		logic [11:0] xfer_length;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/oam_and_vram_dma_controller.sv
`default_nettype none

// Sprite-table and video-memory DMA register block. Each input word is a
// register read, a register write, a cycle tick or a horizontal-blank event,
// and gives exactly one result word: the read byte (0xFF when not a read or
// not decoded) and one transfer descriptor (kind, source, destination,
// length; all zero when nothing moves). An input word is taken every cycle
// unless input stalls, and its result is registered into a two-entry
// output queue; input stalls only while that queue is full.
module oam_and_vram_dma_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] reg_addr,
	input  wire logic [7:0]  write_data,
	input  wire logic [7:0]  tick_cycles,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  read_data,
	output      logic [1:0]  xfer_kind,
	output      logic [15:0] xfer_source,
	output      logic [15:0] xfer_dest,
	output      logic [11:0] xfer_length
);
	import ovdma_pkg::*;

	logic [7:0]  progress_q;
	logic [15:0] sprite_base_q;
	logic [15:0] block_src_q;
	logic [15:0] block_dest_q;
	logic        block_active_q;
	logic [6:0]  block_rem_q;

	logic [7:0]  progress_d;
	logic [15:0] sprite_base_d;
	logic [15:0] block_src_d;
	logic [15:0] block_dest_d;
	logic        block_active_d;
	logic [6:0]  block_rem_d;
	result_t     res;

	logic [7:0]  left;
	logic [7:0]  tick_n;
	logic [11:0] block_len;
	logic        block_go;

	result_t     queue_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	logic        in_acc;
	logic        out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_comb begin
		progress_d     = progress_q;
		sprite_base_d  = sprite_base_q;
		block_src_d    = block_src_q;
		block_dest_d   = block_dest_q;
		block_active_d = block_active_q;
		block_rem_d    = block_rem_q;
		res            = '0;
		res.read_data  = READ_IDLE;
		block_go       = 1'b0;
		block_len      = BLANK_COPY_BYTES;
		left           = SPRITE_BYTES - progress_q;
		tick_n         = (tick_cycles < left) ? tick_cycles : left;

		case (op)
			OP_READ: begin
				case (reg_addr)
					ADDR_SPRITE_START: res.read_data = sprite_base_q[15:8];
					ADDR_SRC_HIGH:     res.read_data = block_src_q[15:8];
					ADDR_SRC_LOW:      res.read_data = block_src_q[7:0];
					ADDR_DEST_HIGH:    res.read_data = block_dest_q[15:8];
					ADDR_DEST_LOW:     res.read_data = block_dest_q[7:0];
					ADDR_CONTROL: begin
						res.read_data = (block_active_q ? 8'h00 : STATUS_IDLE_BIT)
							| {1'b0, block_rem_q};
					end
					default:           res.read_data = READ_IDLE;
				endcase
			end
			OP_WRITE: begin
				case (reg_addr)
					ADDR_SPRITE_START: begin
						progress_d    = 8'd0;
						sprite_base_d = {write_data, 8'h00};
					end
					ADDR_SRC_HIGH: block_src_d = {write_data, block_src_q[7:0]};
					ADDR_SRC_LOW:  block_src_d = {block_src_q[15:8], write_data & LOW_BYTE_MASK};
					ADDR_DEST_HIGH: begin
						block_dest_d = (block_dest_q & DEST_KEEP_MASK)
							| {3'b000, write_data[4:0] & DEST_HIGH_MASK, 8'h00};
					end
					ADDR_DEST_LOW: begin
						block_dest_d = {block_dest_q[15:8], write_data & LOW_BYTE_MASK};
					end
					ADDR_CONTROL: begin
						if (block_active_q) begin
							if (!write_data[7]) begin
								block_active_d = 1'b0;
							end
						end else if (!write_data[7]) begin
							block_go       = 1'b1;
							block_len      = {({1'b0, write_data[6:0]} + 8'd1), 4'h0};
							block_rem_d    = REMAINING_RESET;
							block_active_d = 1'b0;
						end else begin
							block_active_d = 1'b1;
							block_rem_d    = write_data[6:0];
						end
					end
					default: begin
					end
				endcase
			end
			OP_TICK: begin
				if (progress_q < SPRITE_BYTES && tick_cycles != 8'd0) begin
					res.xfer_kind   = KIND_SPRITE;
					res.xfer_source = sprite_base_q + {8'h00, progress_q};
					res.xfer_dest   = {8'h00, progress_q};
					res.xfer_length = {4'h0, tick_n};
					progress_d      = progress_q + tick_n;
				end
			end
			OP_BLANK: begin
				if (block_active_q) begin
					block_go = 1'b1;
					if (block_rem_q != 7'd0) begin
						block_rem_d = block_rem_q - 7'd1;
					end else begin
						block_rem_d    = REMAINING_RESET;
						block_active_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase

		if (block_go) begin
			res.xfer_kind   = KIND_BLOCK;
			res.xfer_source = block_src_q;
			res.xfer_dest   = block_dest_q;
			res.xfer_length = block_len;
			block_src_d     = block_src_q + {4'h0, block_len};
			block_dest_d    = block_dest_q + {4'h0, block_len};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q     <= SPRITE_BYTES;
			sprite_base_q  <= '0;
			block_src_q    <= '0;
			block_dest_q   <= DEST_RESET;
			block_active_q <= 1'b0;
			block_rem_q    <= REMAINING_RESET;
		end else if (in_acc) begin
			progress_q     <= progress_d;
			sprite_base_q  <= sprite_base_d;
			block_src_q    <= block_src_d;
			block_dest_q   <= block_dest_d;
			block_active_q <= block_active_d;
			block_rem_q    <= block_rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_acc) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({in_acc, out_acc})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign in_stall    = count_q[1];
	assign out_valid   = count_q != 2'd0;
	assign read_data   = queue_q[rd_ptr_q].read_data;
	assign xfer_kind   = queue_q[rd_ptr_q].xfer_kind;
	assign xfer_source = queue_q[rd_ptr_q].xfer_source;
	assign xfer_dest   = queue_q[rd_ptr_q].xfer_dest;
	assign xfer_length = queue_q[rd_ptr_q].xfer_length;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output queue overfilled");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

	a_progress_bound: assert property (@(posedge clk) disable iff (!arst_n)
		progress_q <= SPRITE_BYTES)
		else $error("sprite copy ran past table end");

	a_no_desc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && xfer_kind == KIND_NONE |->
		xfer_source == 16'h0000 && xfer_dest == 16'h0000 && xfer_length == 12'h000)
		else $error("empty descriptor carries data");

	a_blank_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op == OP_BLANK && !block_active_q |=> $stable(block_src_q))
		else $error("blank copy while idle");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ovdma_pkg::*;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [7:0]  cyc;
		bit          typed;
		logic [7:0]  typed_read;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_READ;
	logic [15:0] reg_addr = 16'h0000;
	logic [7:0]  write_data = 8'h00;
	logic [7:0]  tick_cycles = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  read_data;
	logic [1:0]  xfer_kind;
	logic [15:0] xfer_source;
	logic [15:0] xfer_dest;
	logic [11:0] xfer_length;

	logic [7:0]  oam_progress;
	logic [15:0] oam_base;
	logic [15:0] hdma_src;
	logic [15:0] hdma_dst;
	logic        hdma_active;
	logic [6:0]  hdma_left;

	result_t     results_due[$];
	stim_row_t   directed_q[$];
	logic [15:0] dma_regs[6] = '{ADDR_SPRITE_START, ADDR_SRC_HIGH, ADDR_SRC_LOW,
		ADDR_DEST_HIGH, ADDR_DEST_LOW, ADDR_CONTROL};

	int errors = 0;
	int words_sent = 0;
	int reads_seen = 0;
	int sprite_seen = 0;
	int block_seen = 0;
	int quiet_seen = 0;
	bit calm = 1'b0;
	bit pressure_done = 1'b0;

	oam_and_vram_dma_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.reg_addr(reg_addr),
		.write_data(write_data),
		.tick_cycles(tick_cycles),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.xfer_kind(xfer_kind),
		.xfer_source(xfer_source),
		.xfer_dest(xfer_dest),
		.xfer_length(xfer_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic stim_row_t row(input logic [1:0] o, input logic [15:0] a,
		input logic [7:0] d, input logic [7:0] c, input bit typed, input logic [7:0] rd);
		stim_row_t s;
		s.op = o;
		s.addr = a;
		s.data = d;
		s.cyc = c;
		s.typed = typed;
		s.typed_read = rd;
		return s;
	endfunction

	task automatic block_move(inout result_t r, input logic [11:0] len);
		r.xfer_kind = KIND_BLOCK;
		r.xfer_source = hdma_src;
		r.xfer_dest = hdma_dst;
		r.xfer_length = len;
		hdma_src = hdma_src + {4'h0, len};
		hdma_dst = hdma_dst + {4'h0, len};
	endtask

	task automatic dma_step(input logic [1:0] o, input logic [15:0] a, input logic [7:0] d,
		input logic [7:0] c, output result_t r);
		logic [7:0] left_b;
		logic [7:0] n;
		r = '0;
		r.read_data = READ_IDLE;
		case (o)
			OP_READ: begin
				case (a)
					ADDR_SPRITE_START: r.read_data = oam_base[15:8];
					ADDR_SRC_HIGH:     r.read_data = hdma_src[15:8];
					ADDR_SRC_LOW:      r.read_data = hdma_src[7:0];
					ADDR_DEST_HIGH:    r.read_data = hdma_dst[15:8];
					ADDR_DEST_LOW:     r.read_data = hdma_dst[7:0];
					ADDR_CONTROL:      r.read_data = (hdma_active ? 8'h00 : STATUS_IDLE_BIT)
						| {1'b0, hdma_left};
					default: ;
				endcase
			end
			OP_WRITE: begin
				case (a)
					ADDR_SPRITE_START: begin
						oam_progress = 8'd0;
						oam_base = {d, 8'h00};
					end
					ADDR_SRC_HIGH:  hdma_src[15:8] = d;
					ADDR_SRC_LOW:   hdma_src[7:0] = d & LOW_BYTE_MASK;
					ADDR_DEST_HIGH: hdma_dst = (hdma_dst & DEST_KEEP_MASK)
						| {3'b000, d[4:0] & DEST_HIGH_MASK, 8'h00};
					ADDR_DEST_LOW:  hdma_dst[7:0] = d & LOW_BYTE_MASK;
					ADDR_CONTROL: begin
						if (hdma_active) begin
							if (!d[7])
								hdma_active = 1'b0;
						end else if (!d[7]) begin
							block_move(r, ({5'd0, d[6:0]} + 12'd1) * BLANK_COPY_BYTES);
							hdma_left = REMAINING_RESET;
						end else begin
							hdma_active = 1'b1;
							hdma_left = d[6:0];
						end
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				if (oam_progress < SPRITE_BYTES && c != 8'd0) begin
					left_b = SPRITE_BYTES - oam_progress;
					n = (c < left_b) ? c : left_b;
					r.xfer_kind = KIND_SPRITE;
					r.xfer_source = oam_base + {8'h00, oam_progress};
					r.xfer_dest = {8'h00, oam_progress};
					r.xfer_length = {4'h0, n};
					oam_progress = oam_progress + n;
				end
			end
			default: begin
				if (hdma_active) begin
					block_move(r, BLANK_COPY_BYTES);
					if (hdma_left != 7'd0) begin
						hdma_left = hdma_left - 7'd1;
					end else begin
						hdma_left = REMAINING_RESET;
						hdma_active = 1'b0;
					end
				end
			end
		endcase
	endtask

	task automatic offer_word(input logic [1:0] o, input logic [15:0] a, input logic [7:0] d,
		input logic [7:0] c, input bit typed, input logic [7:0] rd);
		int gap;
		result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		reg_addr <= a;
		write_data <= d;
		tick_cycles <= c;
		do @(posedge clk); while (in_stall);
		dma_step(o, a, d, c, r);
		if (typed) begin
			r = '0;
			r.read_data = rd;
		end
		results_due.push_back(r);
		words_sent++;
	endtask

	task automatic pick_random_word(output logic [1:0] o, output logic [15:0] a,
		output logic [7:0] d, output logic [7:0] c);
		int r;
		r = $urandom_range(0, 99);
		o = OP_READ;
		a = dma_regs[$urandom_range(0, 5)];
		d = 8'($urandom_range(0, 255));
		c = 8'($urandom_range(0, 255));
		if (r < 10) begin
			o = 2'($urandom_range(0, 3));
			a = 16'($urandom_range(0, 16'hFFFF));
		end else if (r < 28) begin
			o = OP_READ;
		end else if (r < 40) begin
			o = OP_WRITE;
		end else if (r < 46) begin
			o = OP_WRITE;
			a = ADDR_SPRITE_START;
		end else if (r < 68) begin
			o = OP_TICK;
			if ($urandom_range(0, 3) != 0)
				c = 8'($urandom_range(1, 16));
		end else if (r < 88) begin
			o = OP_BLANK;
		end else begin
			o = OP_WRITE;
			a = ADDR_CONTROL;
			if ($urandom_range(0, 1) != 0)
				d[6:0] = 7'($urandom_range(0, 7));
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {read_data, xfer_kind, xfer_source, xfer_dest, xfer_length};
			if (results_due.size() == 0) begin
				if (errors < 10)
					$display("ERROR: unexpected result word %h", got);
				errors++;
			end else begin
				want = results_due.pop_front();
				if (got !== want) begin
					if (errors < 10) begin
						$display("ERROR: mismatch exp rd=%h kind=%0d src=%h dst=%h len=%0d",
							want.read_data, want.xfer_kind, want.xfer_source,
							want.xfer_dest, want.xfer_length);
						$display("                got rd=%h kind=%0d src=%h dst=%h len=%0d",
							got.read_data, got.xfer_kind, got.xfer_source,
							got.xfer_dest, got.xfer_length);
					end
					errors++;
				end
			end
			if (got.read_data != READ_IDLE)
				reads_seen++;
			case (got.xfer_kind)
				KIND_SPRITE: sprite_seen++;
				KIND_BLOCK:  block_seen++;
				default:     quiet_seen++;
			endcase
		end
	end

	initial begin
		int hold;
		hold = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!pressure_done && words_sent >= 120) begin
				pressure_done = 1'b1;
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
			end else if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				hold = pick_gap();
				out_stall <= (hold > 0);
				if (hold > 0)
					hold--;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding", results_due.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [1:0]  o;
		logic [15:0] a;
		logic [7:0]  d;
		logic [7:0]  c;
		oam_progress = SPRITE_BYTES;
		oam_base = 16'h0000;
		hdma_src = 16'h0000;
		hdma_dst = DEST_RESET;
		hdma_active = 1'b0;
		hdma_left = REMAINING_RESET;

		directed_q.push_back(row(OP_READ,  ADDR_CONTROL,      8'h00, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_READ,  ADDR_DEST_HIGH,    8'h00, 8'h00, 1'b1, 8'h80));
		directed_q.push_back(row(OP_READ,  ADDR_SPRITE_START, 8'h00, 8'h00, 1'b1, 8'h00));
		directed_q.push_back(row(OP_READ,  16'h0000,          8'h00, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_WRITE, 16'hFFFF,          8'hFF, 8'hFF, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_TICK,  16'h0000,          8'h00, 8'hFF, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_BLANK, 16'hFFFF,          8'hFF, 8'hFF, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_WRITE, ADDR_SRC_HIGH,     8'hFF, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_WRITE, ADDR_SRC_LOW,      8'hFF, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_WRITE, ADDR_DEST_HIGH,    8'hFF, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_WRITE, ADDR_DEST_LOW,     8'hFF, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_READ,  ADDR_SRC_LOW,      8'h00, 8'h00, 1'b0, 8'h00));
		directed_q.push_back(row(OP_READ,  ADDR_DEST_HIGH,    8'h00, 8'h00, 1'b0, 8'h00));
		directed_q.push_back(row(OP_WRITE, ADDR_CONTROL,      8'h7F, 8'h00, 1'b0, 8'h00));
		directed_q.push_back(row(OP_READ,  ADDR_CONTROL,      8'h00, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_WRITE, ADDR_CONTROL,      8'h80, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_WRITE, ADDR_CONTROL,      8'h85, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_READ,  ADDR_CONTROL,      8'h00, 8'h00, 1'b1, 8'h00));
		directed_q.push_back(row(OP_BLANK, 16'h0000,          8'h00, 8'h00, 1'b0, 8'h00));
		directed_q.push_back(row(OP_WRITE, ADDR_CONTROL,      8'h82, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_BLANK, 16'h0000,          8'h00, 8'h00, 1'b0, 8'h00));
		directed_q.push_back(row(OP_WRITE, ADDR_CONTROL,      8'h00, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_READ,  ADDR_CONTROL,      8'h00, 8'h00, 1'b1, 8'h81));
		directed_q.push_back(row(OP_WRITE, ADDR_SPRITE_START, 8'hFF, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_TICK,  16'h0000,          8'h00, 8'h00, 1'b1, 8'hFF));
		directed_q.push_back(row(OP_TICK,  16'h0000,          8'h00, 8'hFF, 1'b0, 8'h00));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_q[i])
			offer_word(directed_q[i].op, directed_q[i].addr, directed_q[i].data,
				directed_q[i].cyc, directed_q[i].typed, directed_q[i].typed_read);

		for (int i = 0; i < 925; i++) begin
			calm = (i >= 400 && i < 550);
			pick_random_word(o, a, d, c);
			offer_word(o, a, d, c, 1'b0, 8'h00);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d words: %0d directed, the rest random with gaps and a long output hold.",
			words_sent, directed_q.size());
		$display("Results: %0d reads, %0d sprite copies, %0d block copies, %0d with no transfer.",
			reads_seen, sprite_seen, block_seen, quiet_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
